/* src/tmcr_pkg.sv */
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types and constants of the tile map cell renderer: request codes,
// register indexes, channel widths and the reduce unit command.
// ----------------------------------------------------------------------------
package tmcr_pkg;

   localparam int PATTERN_BYTES_DEF = 65536;
   localparam int MAP_COLUMNS_DEF   = 32;
   localparam int MAP_ROWS_DEF      = 28;
   localparam int PALETTE_ENTRIES   = 256;
   localparam int PAL_AW            = 8;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int PIX_W      = 16;
   localparam int PIXELS     = 8;
   localparam int RSP_DATA_W = PIX_W * PIXELS + 16;

   // byte address before wrap: tile * 32 + row * 4 + column, up to 17 bits
   localparam int VAL_W = 17;
   localparam int K_W   = 3;

   localparam logic [1:0] MODE_PAT    = 2'd0;
   localparam logic [1:0] MODE_PAL    = 2'd1;
   localparam logic [1:0] MODE_MAP    = 2'd2;
   localparam logic [1:0] MODE_RENDER = 2'd3;

   localparam logic [1:0] CSR_BANK0  = 2'd0;
   localparam logic [1:0] CSR_BANK1  = 2'd1;
   localparam logic [1:0] CSR_TWO_D0 = 2'd2;
   localparam logic [1:0] CSR_TWO_D1 = 2'd3;

   localparam int ENT_TILE_W = 11;
   localparam int ENT_PAL_LO = 12;
   localparam int ENT_HFLIP  = 14;
   localparam int ENT_VFLIP  = 15;

   typedef struct packed {
      logic           en;
      logic           load;
      logic [K_W-1:0] k;
   } red_ctrl_type;

endpackage

/* src/tile_map_cell_renderer_unit.sv */
// ----------------------------------------------------------------------------
// tile_map_cell_renderer_unit
// Palette and map writes are taken when accepted; a pattern write first reduces
//   its address in S = 18 - clog2(PATTERN_BYTES) reduce steps (2 at 64 KiB).
// A render returns 8 rows in 1D, 32 rows in 2D; every row is reduced on the
//   shared compare-subtract unit, and each pixel takes one palette read.
// One request at a time; the last row may wait in the output register.
// Reset (synchronous) clears control and csr state; stores are not cleared.
// ----------------------------------------------------------------------------
module tile_map_cell_renderer_unit #(
   parameter int PATTERN_BYTES = tmcr_pkg::PATTERN_BYTES_DEF,
   parameter int MAP_COLUMNS   = tmcr_pkg::MAP_COLUMNS_DEF,
   parameter int MAP_ROWS      = tmcr_pkg::MAP_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address[15:0], write_data[31:16], cell_x[36:32], cell_y[41:37], zero fill
   input  logic [tmcr_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0], screen[2]
   input  logic [tmcr_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_0[15:0] .. pixel_7[127:112], row_x[135:128], row_y[143:136]
   output logic [tmcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [1:0]                      csr_wdata
);

   localparam int CELLS     = MAP_COLUMNS * MAP_ROWS;
   localparam int MAP_DEPTH = 2 * CELLS;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int PAT_AW    = $clog2(PATTERN_BYTES);
   localparam int STEPS     = tmcr_pkg::VAL_W + 1 - PAT_AW;
   localparam logic [tmcr_pkg::K_W-1:0] K_TOP = tmcr_pkg::K_W'(STEPS - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ENTRY = 4'd1;
   localparam logic [3:0] S_ROW   = 4'd2;
   localparam logic [3:0] S_RED   = 4'd3;
   localparam logic [3:0] S_PWR   = 4'd4;
   localparam logic [3:0] S_PADDR = 4'd5;
   localparam logic [3:0] S_PREAD = 4'd6;
   localparam logic [3:0] S_PNIB  = 4'd7;
   localparam logic [3:0] S_PCAP  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   // request fields
   logic [1:0]  req_mode;
   logic        req_screen;
   logic [15:0] req_address;
   logic [15:0] req_wdata;
   logic [4:0]  req_cx;
   logic [4:0]  req_cy;

   assign req_mode    = req_tuser[1:0];
   assign req_screen  = req_tuser[2];
   assign req_address = req_tdata[15:0];
   assign req_wdata   = req_tdata[31:16];
   assign req_cx      = req_tdata[36:32];
   assign req_cy      = req_tdata[41:37];

   // control state
   logic [3:0]                 state_ff, state_in;
   logic [tmcr_pkg::K_W-1:0]   kcnt_ff, kcnt_in;
   logic [4:0]                 row_ff, row_in;
   logic [2:0]                 px_ff, px_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 bank0_ff, bank1_ff;
   logic                       two_d0_ff, two_d1_ff;

   // payload
   logic [1:0]                 mode_ff;
   logic                       two_d_ff;
   logic [1:0]                 bank_ff;
   logic [4:0]                 cx_ff, cy_ff;
   logic [7:0]                 wdata_ff;
   logic [tmcr_pkg::ENT_TILE_W-1:0] tile_ff;
   logic [1:0]                 pidx_ff;
   logic                       hflip_ff, vflip_ff;
   logic [PAT_AW-1:0]          rb_ff;
   logic [tmcr_pkg::PIX_W-1:0] pix_ff [tmcr_pkg::PIXELS];
   logic [tmcr_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;

   logic accept;
   logic sel_two_d;
   logic in_bounds;
   logic out_free;

   // reduce unit
   tmcr_pkg::red_ctrl_type     red_ctrl;
   logic [tmcr_pkg::VAL_W-1:0] red_load;
   logic [tmcr_pkg::VAL_W-1:0] red_acc;
   logic [tmcr_pkg::VAL_W-1:0] red_next;

   // row and pixel datapath
   logic [3:0]                 row_r;
   logic                       row_h;
   logic [3:0]                 tile_off;
   logic [11:0]                tile_num;
   logic [2:0]                 sy;
   logic [tmcr_pkg::VAL_W-1:0] row_base;
   logic                       row_last;
   logic [7:0]                 row_x;
   logic [7:0]                 row_y;
   logic [2:0]                 sx;
   logic [tmcr_pkg::VAL_W-1:0] byte_val;
   logic [3:0]                 nib;
   logic [7:0]                 pal_base;

   // memory ports
   logic                         pat_we, pat_re;
   logic [7:0]                   pat_rdata;
   logic                         pal_we, pal_re;
   logic [tmcr_pkg::PAL_AW-1:0]  pal_raddr;
   logic [tmcr_pkg::PIX_W-1:0]   pal_rdata;
   logic                         map_we, map_re;
   logic [MAP_AW-1:0]            map_base;
   logic [MAP_AW-1:0]            map_waddr;
   logic [MAP_AW-1:0]            map_raddr;
   logic [15:0]                  map_rdata;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sel_two_d  = req_screen ? two_d1_ff : two_d0_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (sel_two_d) begin
         in_bounds = ({1'b0, req_cx} < 6'(MAP_COLUMNS / 2)) &&
                     ({1'b0, req_cy} < 6'(MAP_ROWS / 2));
      end else begin
         in_bounds = ({1'b0, req_cx} < 6'(MAP_COLUMNS)) &&
                     ({1'b0, req_cy} < 6'(MAP_ROWS));
      end
   end

   // row geometry
   always_comb begin
      row_r    = two_d_ff ? row_ff[4:1] : {1'b0, row_ff[2:0]};
      row_h    = two_d_ff & row_ff[0];
      tile_off = two_d_ff ? {row_r[3] ^ vflip_ff, 2'b00, row_h ^ hflip_ff} : 4'd0;
      tile_num = {1'b0, tile_ff} + 12'(tile_off);
      sy       = row_r[2:0] ^ {3{vflip_ff}};
      row_base = {tile_num, 5'b0} + tmcr_pkg::VAL_W'({sy, 2'b00});
      row_last = two_d_ff ? (row_ff == 5'd31) : (row_ff == 5'd7);
      row_x    = two_d_ff ? {cx_ff[3:0], row_h, 3'b000} : {cx_ff, 3'b000};
      row_y    = two_d_ff ? ({cy_ff[3:0], 4'b0000} + {4'b0000, row_r})
                          : ({cy_ff, 3'b000} + {4'b0000, row_r});
      sx       = px_ff ^ {3{hflip_ff}};
      byte_val = tmcr_pkg::VAL_W'(rb_ff) + tmcr_pkg::VAL_W'(sx[2:1]);
      nib      = sx[0] ? pat_rdata[3:0] : pat_rdata[7:4];
      pal_base = {bank_ff, pidx_ff, 4'b0000};
      pal_raddr = pal_base + {4'b0000, nib};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kcnt_in       = kcnt_ff;
      row_in        = row_ff;
      px_in         = px_ff;
      red_ctrl      = '0;
      red_load      = '0;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  tmcr_pkg::MODE_PAT: begin
                     red_ctrl.en   = 1'b1;
                     red_ctrl.load = 1'b1;
                     red_ctrl.k    = K_TOP;
                     red_load      = tmcr_pkg::VAL_W'(req_address);
                     kcnt_in       = K_TOP - 1'b1;
                     state_in      = (K_TOP == '0) ? S_PWR : S_RED;
                  end
                  tmcr_pkg::MODE_RENDER: begin
                     row_in = '0;
                     if (in_bounds) begin
                        state_in = S_ENTRY;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ENTRY: begin
            state_in = S_ROW;
         end
         S_ROW: begin
            red_ctrl.en   = 1'b1;
            red_ctrl.load = 1'b1;
            red_ctrl.k    = K_TOP;
            red_load      = row_base;
            kcnt_in       = K_TOP - 1'b1;
            px_in         = '0;
            state_in      = (K_TOP == '0) ? S_PADDR : S_RED;
         end
         S_RED: begin
            red_ctrl.en = 1'b1;
            red_ctrl.k  = kcnt_ff;
            kcnt_in     = kcnt_ff - 1'b1;
            px_in       = '0;
            if (kcnt_ff == '0) begin
               state_in = (mode_ff == tmcr_pkg::MODE_PAT) ? S_PWR : S_PADDR;
            end
         end
         S_PWR: begin
            state_in = S_IDLE;
         end
         S_PADDR: begin
            red_ctrl.en   = 1'b1;
            red_ctrl.load = 1'b1;
            red_ctrl.k    = '0;
            red_load      = byte_val;
            state_in      = S_PREAD;
         end
         S_PREAD: begin
            state_in = S_PNIB;
         end
         S_PNIB: begin
            state_in = S_PCAP;
         end
         S_PCAP: begin
            px_in    = px_ff + 1'b1;
            state_in = (px_ff == 3'd7) ? S_EMIT : S_PADDR;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               row_in       = row_ff + 1'b1;
               state_in     = row_last ? S_IDLE : S_ROW;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kcnt_ff      <= '0;
         row_ff       <= '0;
         px_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         bank0_ff     <= '0;
         bank1_ff     <= '0;
         two_d0_ff    <= 1'b0;
         two_d1_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kcnt_ff      <= kcnt_in;
         row_ff       <= row_in;
         px_ff        <= px_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               tmcr_pkg::CSR_BANK0:  bank0_ff  <= csr_wdata;
               tmcr_pkg::CSR_BANK1:  bank1_ff  <= csr_wdata;
               tmcr_pkg::CSR_TWO_D0: two_d0_ff <= csr_wdata[0];
               tmcr_pkg::CSR_TWO_D1: two_d1_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         two_d_ff <= sel_two_d;
         bank_ff  <= req_screen ? bank1_ff : bank0_ff;
         cx_ff    <= req_cx;
         cy_ff    <= req_cy;
         wdata_ff <= req_wdata[7:0];
      end
      if (state_ff == S_ENTRY) begin
         tile_ff  <= map_rdata[tmcr_pkg::ENT_TILE_W-1:0];
         pidx_ff  <= map_rdata[tmcr_pkg::ENT_PAL_LO +: 2];
         hflip_ff <= map_rdata[tmcr_pkg::ENT_HFLIP];
         vflip_ff <= map_rdata[tmcr_pkg::ENT_VFLIP];
      end
      if (state_ff == S_ROW || state_ff == S_RED) begin
         rb_ff <= red_next[PAT_AW-1:0];
      end
      if (state_ff == S_PCAP) begin
         pix_ff[px_ff] <= pal_rdata;
      end
      if (state_ff == S_EMIT && out_free) begin
         rsp_data_ff <= {row_y, row_x, pix_ff[7], pix_ff[6], pix_ff[5], pix_ff[4],
                         pix_ff[3], pix_ff[2], pix_ff[1], pix_ff[0]};
         rsp_last_ff <= row_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   tmcr_reduce #(
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_reduce (
      .clock    (clock),
      .ctrl     (red_ctrl),
      .load_val (red_load),
      .acc      (red_acc),
      .acc_next (red_next)
   );

   // store ports
   assign pat_we    = (state_ff == S_PWR);
   assign pat_re    = (state_ff == S_PREAD);
   assign pal_we    = accept && (req_mode == tmcr_pkg::MODE_PAL) &&
                      (req_address[15:tmcr_pkg::PAL_AW] == '0);
   assign pal_re    = (state_ff == S_PNIB);
   assign map_base  = req_screen ? MAP_AW'(CELLS) : '0;
   assign map_we    = accept && (req_mode == tmcr_pkg::MODE_MAP) &&
                      (req_address < 16'(CELLS));
   assign map_waddr = map_base + MAP_AW'(req_address);
   assign map_re    = accept && (req_mode == tmcr_pkg::MODE_RENDER);
   assign map_raddr = map_base + MAP_AW'(req_cy) * MAP_AW'(MAP_COLUMNS) + MAP_AW'(req_cx);

   tmcr_ram #(
      .DATA_W (8),
      .DEPTH  (PATTERN_BYTES)
   ) u_pattern (
      .clock (clock),
      .we    (pat_we),
      .waddr (red_acc[PAT_AW-1:0]),
      .wdata (wdata_ff),
      .re    (pat_re),
      .raddr (red_acc[PAT_AW-1:0]),
      .rdata (pat_rdata)
   );

   tmcr_ram #(
      .DATA_W (tmcr_pkg::PIX_W),
      .DEPTH  (tmcr_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_address[tmcr_pkg::PAL_AW-1:0]),
      .wdata (req_wdata),
      .re    (pal_re),
      .raddr (pal_raddr),
      .rdata (pal_rdata)
   );

   tmcr_ram #(
      .DATA_W (16),
      .DEPTH  (MAP_DEPTH)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (req_wdata),
      .re    (map_re),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

endmodule

/* src/tmcr_ram.sv */
// ----------------------------------------------------------------------------
// tmcr_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tmcr_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/tmcr_reduce.sv */
// ----------------------------------------------------------------------------
// tmcr_reduce
// Shared compare-subtract unit: one restoring step of a reduction modulo the
// pattern store size per command, on its own accumulator.
// ----------------------------------------------------------------------------
module tmcr_reduce #(
   parameter int PATTERN_BYTES = tmcr_pkg::PATTERN_BYTES_DEF
) (
   input  logic                       clock,
   input  tmcr_pkg::red_ctrl_type     ctrl,
   input  logic [tmcr_pkg::VAL_W-1:0] load_val,
   output logic [tmcr_pkg::VAL_W-1:0] acc,
   output logic [tmcr_pkg::VAL_W-1:0] acc_next
);

   localparam int PAT_AW = $clog2(PATTERN_BYTES);
   localparam int STEPS  = tmcr_pkg::VAL_W + 1 - PAT_AW;
   localparam int WIDE_W = tmcr_pkg::VAL_W + STEPS;

   logic [tmcr_pkg::VAL_W-1:0] acc_ff;
   logic [tmcr_pkg::VAL_W-1:0] acc_in;
   logic [WIDE_W-1:0]          operand;
   logic [WIDE_W-1:0]          divisor;
   logic [WIDE_W-1:0]          diff;

   always_comb begin
      operand  = WIDE_W'(ctrl.load ? load_val : acc_ff);
      divisor  = WIDE_W'(PATTERN_BYTES) << ctrl.k;
      diff     = operand - divisor;
      acc_next = (operand >= divisor) ? diff[tmcr_pkg::VAL_W-1:0]
                                      : operand[tmcr_pkg::VAL_W-1:0];
      acc_in   = ctrl.en ? acc_next : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* src/tmcr_checker.sv */
// ----------------------------------------------------------------------------
// tmcr_checker
// Port-level checks of the tile map cell renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tmcr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tmcr_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tmcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // a pattern write goes through the reduce unit and blocks the next request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[1:0] == tmcr_pkg::MODE_PAT |=> !req_tready)
      else $error("pattern write did not occupy the sequencer");

   // reset empties the output register and returns to idle
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output or sequencer not cleared by reset");

endmodule

bind tile_map_cell_renderer_unit tmcr_checker u_tmcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tile_map_cell_renderer_unit. Requests stream in
// bursts from a queue; accepted writes update a local copy of the
// pattern, palette and map stores, and renders are expanded into the rows the
// block must return. Rows are checked field by field in order while the
// response side stalls on its own pattern. Phases run under several register
// settings in 1D and 2D cell mapping.
// ----------------------------------------------------------------------------
module testbench;
   import tmcr_pkg::*;

   localparam int CELLS       = MAP_COLUMNS_DEF * MAP_ROWS_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 2000;
   localparam int TAIL_CYCLES = 1200;
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [15:0] write_data;
      logic        screen;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
   } request_t;

   typedef struct packed {
      logic            last;
      logic [7:0]      row_y;
      logic [7:0]      row_x;
      logic [7:0][15:0] pix;
   } pixel_row_t;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_style_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [1:0]            csr_wdata = '0;

   // local copy of the block's state
   logic [7:0]  pat_bytes [PATTERN_BYTES_DEF];
   logic [15:0] pal_colors [PALETTE_ENTRIES];
   logic [15:0] map_cells [2 * CELLS];
   logic [1:0]  bank_sel [2] = '{2'd0, 2'd0};
   logic        two_d_on [2] = '{1'b0, 1'b0};

   // what the request generator has already written
   bit pat_set [PATTERN_BYTES_DEF];
   bit map_set [2 * CELLS];
   int tile_pool [12];

   request_t   pending [$];
   pixel_row_t rows_due [$];
   request_t   offered;
   int         queued_count = 0;
   int         accepted_count = 0;
   int         faults = 0;
   int         burst_left = 4;
   int         gap_left = 0;
   int         idle_cycles = 0;
   bit         hold_ask = 1'b0;
   int         hold_left = 0;
   int         style_left = 0;
   ready_style_t style = READY_ALWAYS;

   tile_map_cell_renderer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic pixel_row_t shade_row(input int tile, input int row, input logic hf,
                                            input logic vf, input int pal_base, input int rx,
                                            input int ry, input logic last);
      pixel_row_t o;
      int         px, sx, sy, addr, nib;
      logic [7:0] b;
      sy = vf ? (row ^ 7) : row;
      for (px = 0; px < 8; px++) begin
         sx = hf ? (px ^ 7) : px;
         addr = (tile * 32 + sy * 4 + sx / 2) % PATTERN_BYTES_DEF;
         b = pat_bytes[addr];
         nib = (sx & 1) ? int'(b[3:0]) : int'(b[7:4]);
         o.pix[px] = pal_colors[(nib + pal_base) % PALETTE_ENTRIES];
      end
      o.row_x = rx[7:0];
      o.row_y = ry[7:0];
      o.last = last;
      return o;
   endfunction

   task automatic paint_cell(input request_t r);
      logic [15:0] entry;
      logic        hf, vf, td;
      int          tile, pal_base, row, half, qx, qy;
      td = two_d_on[r.screen];
      if (td ? (r.cell_x >= MAP_COLUMNS_DEF / 2 || r.cell_y >= MAP_ROWS_DEF / 2)
             : (r.cell_y >= MAP_ROWS_DEF))
         return;
      entry = map_cells[int'(r.screen) * CELLS + int'(r.cell_y) * MAP_COLUMNS_DEF
                        + int'(r.cell_x)];
      tile = int'(entry[ENT_TILE_W-1:0]);
      hf = entry[ENT_HFLIP];
      vf = entry[ENT_VFLIP];
      pal_base = (int'(bank_sel[r.screen]) * 4 + int'(entry[ENT_PAL_LO +: 2])) * 16;
      if (!td) begin
         for (row = 0; row < 8; row++)
            rows_due.push_back(shade_row(tile, row, hf, vf, pal_base, 8 * int'(r.cell_x),
                                         8 * int'(r.cell_y) + row, row == 7));
      end else begin
         for (row = 0; row < 16; row++) begin
            for (half = 0; half < 2; half++) begin
               qy = (row / 8) ^ int'(vf);
               qx = half ^ int'(hf);
               rows_due.push_back(shade_row(tile + qy * 8 + qx, row % 8, hf, vf, pal_base,
                                            16 * int'(r.cell_x) + 8 * half,
                                            16 * int'(r.cell_y) + row,
                                            row == 15 && half == 1));
            end
         end
      end
   endtask

   task automatic take_request(input request_t r);
      case (r.mode)
         MODE_PAT: pat_bytes[r.address] = r.write_data[7:0];
         MODE_PAL: if (r.address < PALETTE_ENTRIES) pal_colors[r.address] = r.write_data;
         MODE_MAP: if (r.address < CELLS)
            map_cells[int'(r.screen) * CELLS + int'(r.address)] = r.write_data;
         default: paint_cell(r);
      endcase
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_request(offered);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               offered = pending.pop_front();
               req_tdata <= {6'd0, offered.cell_y, offered.cell_x, offered.write_data,
                             offered.address};
               req_tuser <= {offered.screen, offered.mode};
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
               end
            end
         end
      end
   end

   // receiver: stall pattern plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_ask) begin
         hold_ask = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            style = ready_style_t'($urandom_range(0, 2));
            style_left = $urandom_range(16, 160);
         end
         style_left--;
         case (style)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= $urandom_range(0, 1);
            default:      rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // row checker
   always @(posedge clock) begin
      pixel_row_t want;
      int         px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rows_due.size() == 0) begin
            $display("%0t: unexpected row expected none actual %h last %b", $time, rsp_tdata,
                     rsp_tlast);
            faults++;
         end else begin
            want = rows_due.pop_front();
            for (px = 0; px < 8; px++) begin
               if (rsp_tdata[px * 16 +: 16] !== want.pix[px]) begin
                  $display("%0t: pixel_%0d expected %h actual %h", $time, px, want.pix[px],
                           rsp_tdata[px * 16 +: 16]);
                  faults++;
               end
            end
            if (rsp_tdata[135:128] !== want.row_x) begin
               $display("%0t: row_x expected %0d actual %0d", $time, want.row_x,
                        rsp_tdata[135:128]);
               faults++;
            end
            if (rsp_tdata[143:136] !== want.row_y) begin
               $display("%0t: row_y expected %0d actual %0d", $time, want.row_y,
                        rsp_tdata[143:136]);
               faults++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               faults++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_req(input logic [1:0] mode, input logic [15:0] addr,
                           input logic [15:0] data, input logic scr, input logic [4:0] cx,
                           input logic [4:0] cy);
      request_t r;
      r.mode = mode;
      r.address = addr;
      r.write_data = data;
      r.screen = scr;
      r.cell_x = cx;
      r.cell_y = cy;
      pending.push_back(r);
      queued_count++;
   endtask

   task automatic put_pattern(input int addr, input logic [15:0] data);
      pat_set[addr] = 1'b1;
      push_req(MODE_PAT, addr[15:0], data, $urandom, $urandom, $urandom);
   endtask

   task automatic put_map(input logic scr, input int addr, input logic [15:0] entry);
      if (addr < CELLS) map_set[int'(scr) * CELLS + addr] = 1'b1;
      push_req(MODE_MAP, addr[15:0], entry, scr, $urandom, $urandom);
   endtask

   task automatic fill_tile(input int t);
      int k, a;
      for (k = 0; k < 32; k++) begin
         a = (t * 32 + k) % PATTERN_BYTES_DEF;
         if (!pat_set[a]) put_pattern(a, $urandom);
      end
   endtask

   function automatic logic [15:0] random_entry();
      logic [15:0] e;
      int          t;
      e = $urandom;
      t = tile_pool[$urandom_range(0, 11)];
      e[ENT_TILE_W-1:0] = t[ENT_TILE_W-1:0];
      return e;
   endfunction

   // render request, preceded by whatever map and pattern writes it needs
   task automatic render_cell(input logic scr, input int cx, input int cy);
      int          idx, tile;
      logic [15:0] entry;
      bit          td, hit;
      td = two_d_on[scr];
      hit = td ? (cx < MAP_COLUMNS_DEF / 2 && cy < MAP_ROWS_DEF / 2) : (cy < MAP_ROWS_DEF);
      if (hit) begin
         idx = cy * MAP_COLUMNS_DEF + cx;
         if (!map_set[int'(scr) * CELLS + idx]) put_map(scr, idx, random_entry());
         entry = map_cells_pending(scr, idx);
         tile = int'(entry[ENT_TILE_W-1:0]);
         fill_tile(tile);
         if (td) begin
            fill_tile(tile + 1);
            fill_tile(tile + 8);
            fill_tile(tile + 9);
         end
      end
      push_req(MODE_RENDER, $urandom, $urandom, scr, cx[4:0], cy[4:0]);
   endtask

   // latest map entry queued for a cell, searching unsent requests first
   function automatic logic [15:0] map_cells_pending(input logic scr, input int idx);
      int i;
      for (i = pending.size() - 1; i >= 0; i--)
         if (pending[i].mode == MODE_MAP && pending[i].screen == scr &&
             int'(pending[i].address) == idx)
            return pending[i].write_data;
      if (offered.mode == MODE_MAP && offered.screen == scr && int'(offered.address) == idx &&
          req_tvalid)
         return offered.write_data;
      return map_cells[int'(scr) * CELLS + idx];
   endfunction

   task automatic set_config(input logic [1:0] b0, input logic [1:0] b1, input logic t0,
                             input logic t1);
      logic [1:0] idx [4];
      logic [1:0] val [4];
      int         i;
      idx = '{CSR_BANK0, CSR_BANK1, CSR_TWO_D0, CSR_TWO_D1};
      val = '{b0, b1, {1'b0, t0}, {1'b0, t1}};
      for (i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
      end
      bank_sel[0] = b0;
      bank_sel[1] = b1;
      two_d_on[0] = t0;
      two_d_on[1] = t1;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (accepted_count != queued_count || rows_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic random_requests(input int count);
      int   i, pick, cx, cy;
      logic scr;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         scr = $urandom_range(0, 1);
         if (pick < 45) begin
            cx = two_d_on[scr] ? $urandom_range(0, 15) : $urandom_range(0, 31);
            cy = two_d_on[scr] ? $urandom_range(0, 13) : $urandom_range(0, 27);
            render_cell(scr, cx, cy);
         end else if (pick < 60) begin
            put_map(scr, $urandom_range(0, CELLS - 1), random_entry());
         end else if (pick < 72) begin
            put_pattern($urandom_range(0, 65535), $urandom);
         end else if (pick < 82) begin
            push_req(MODE_PAL, $urandom_range(0, 255), $urandom, scr, $urandom, $urandom);
         end else if (pick < 88) begin
            if (two_d_on[scr]) render_cell(scr, $urandom_range(16, 31), $urandom_range(0, 31));
            else render_cell(scr, $urandom_range(0, 31), $urandom_range(28, 31));
         end else if (pick < 94) begin
            if (pick & 1)
               push_req(MODE_PAL, $urandom_range(256, 65535), $urandom, scr, $urandom,
                        $urandom);
            else
               push_req(MODE_MAP, $urandom_range(CELLS, 65535), $urandom, scr, $urandom,
                        $urandom);
         end else begin
            render_cell(scr, $urandom_range(0, 31), $urandom_range(0, 31));
         end
      end
   endtask

   initial begin
      int i;
      tile_pool[0] = 0;
      tile_pool[1] = 2047;
      for (i = 2; i < 12; i++) tile_pool[i] = $urandom_range(0, 2047);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // 1D, register values as after reset
      set_config(2'd0, 2'd0, 1'b0, 1'b0);
      for (i = 0; i < PALETTE_ENTRIES; i++)
         push_req(MODE_PAL, i, $urandom, $urandom, $urandom, $urandom);
      put_pattern(65535, 16'hffff);
      push_req(MODE_PAL, 16'd256, 16'hffff, 1'b0, 5'd0, 5'd0);
      push_req(MODE_PAL, 16'hffff, 16'h1234, 1'b1, 5'd31, 5'd31);
      push_req(MODE_MAP, CELLS, 16'hffff, 1'b0, 5'd0, 5'd0);
      push_req(MODE_MAP, 16'hffff, 16'hffff, 1'b1, 5'd31, 5'd31);
      put_map(1'b0, 0, 16'h0000);
      render_cell(1'b0, 0, 0);
      put_map(1'b1, CELLS - 1, 16'hf7ff);
      render_cell(1'b1, 31, 27);
      put_map(1'b0, 3 * 32 + 5, 16'h4005);
      render_cell(1'b0, 5, 3);
      put_map(1'b0, 3 * 32 + 6, 16'h8809);
      render_cell(1'b0, 6, 3);
      render_cell(1'b0, 31, 28);
      render_cell(1'b1, 31, 31);
      settle();

      // 2D on both screens, tile wrap past the pattern store
      set_config(2'd3, 2'd1, 1'b1, 1'b1);
      put_map(1'b0, 13 * 32 + 15, 16'hc7ff);
      render_cell(1'b0, 15, 13);
      put_map(1'b1, 0, 16'h4001);
      render_cell(1'b1, 0, 0);
      put_map(1'b1, 1, 16'h9064);
      render_cell(1'b1, 1, 0);
      render_cell(1'b0, 0, 0);
      render_cell(1'b0, 16, 0);
      render_cell(1'b1, 0, 14);
      render_cell(1'b0, 31, 31);
      settle();

      set_config(2'd1, 2'd2, 1'b0, 1'b1);
      random_requests(PHASE_ITEMS);
      settle();

      set_config(2'd0, 2'd3, 1'b1, 1'b0);
      random_requests(PHASE_ITEMS);
      hold_ask = 1'b1;
      settle();

      set_config(2'd3, 2'd3, 1'b0, 1'b0);
      random_requests(PHASE_ITEMS);
      settle();

      set_config(2'd2, 2'd1, 1'b1, 1'b1);
      random_requests(PHASE_ITEMS);
      settle();

      if (faults == 0 && rows_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
